@@ hdl/gyro_flex_gesture_classifier_defines.svh @@
// ----------------------------------------------------------------------------
// gyro_flex_gesture_classifier_defines.svh
// Assertion macros shared by the checker of the gesture classifier
// ----------------------------------------------------------------------------
`ifndef GYRO_FLEX_GESTURE_CLASSIFIER_DEFINES_SVH
`define GYRO_FLEX_GESTURE_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define GFG_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define GFG_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

@@ hdl/gfg_pkg.sv @@
// ----------------------------------------------------------------------------
// gfg_pkg
// Types and constants of the gyro and flex gesture classifier
// ----------------------------------------------------------------------------
package gfg_pkg;

    // apb address width: six registers at 4-byte spacing
    localparam int AddrWidth = 5;
    localparam int DataWidth = 32;

    // register map, index = byte address / 4
    typedef enum logic [2:0] {
        REG_OFFSET_X         = 3'd0,
        REG_OFFSET_Y         = 3'd1,
        REG_OFFSET_Z         = 3'd2,
        REG_COOLDOWN_MS      = 3'd3,
        REG_ROTATE_THRESHOLD = 3'd4,
        REG_DEAD_ZONE        = 3'd5
    } reg_idx_t;

    // gesture codes, equal to the track number
    typedef enum logic [2:0] {
        GEST_NONE     = 3'd0,
        GEST_INDEX    = 3'd1,
        GEST_THUMB    = 3'd2,
        GEST_PINKY    = 3'd3,
        GEST_TURN_POS = 3'd4,
        GEST_TURN_NEG = 3'd5
    } gesture_t;

    // register reset values
    localparam logic [15:0] CooldownReset  = 16'd1000;
    localparam logic [22:0] RotateReset    = 23'd670720;
    localparam logic [22:0] DeadZoneReset  = 23'd16768;

    // flex windows, inclusive
    localparam logic [11:0] IndexLo = 12'd1390;
    localparam logic [11:0] IndexHi = 12'd1430;
    localparam logic [11:0] ThumbLo = 12'd1400;
    localparam logic [11:0] ThumbHi = 12'd1450;
    localparam logic [11:0] PinkyLo = 12'd1720;
    localparam logic [11:0] PinkyHi = 12'd1780;

    // low-pass weights, alpha = 205/256
    localparam logic signed [33:0] KeepWeight = 34'sd205;
    localparam logic signed [33:0] NewWeight  = 34'sd51;

    // saturation bounds of a 24-bit rate, held at 26 bits
    localparam logic signed [25:0] RateMax = 26'sd8388607;
    localparam logic signed [25:0] RateMin = -26'sd8388608;

    typedef struct packed {
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] offset_z;
        logic        [15:0] cooldown_ms;
        logic        [22:0] rotate_threshold;
        logic        [22:0] dead_zone;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] gyro_raw_x;
        logic signed [15:0] gyro_raw_y;
        logic signed [15:0] gyro_raw_z;
        logic        [11:0] thumb_level;
        logic        [11:0] index_level;
        logic        [11:0] pinky_level;
        logic        [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] rate_x;
        logic signed [23:0] rate_y;
        logic signed [23:0] rate_z;
        logic               play;
        logic        [2:0]  track;
    } out_item_t;

endpackage

@@ hdl/gfg_if.sv @@
// ----------------------------------------------------------------------------
// gfg_in_if / gfg_out_if
// Valid/ready channels for sensor samples and classifier results
// ----------------------------------------------------------------------------
interface gfg_in_if;
    import gfg_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gfg_out_if;
    import gfg_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/gfg_apb_regs.sv @@
// ----------------------------------------------------------------------------
// gfg_apb_regs
// APB register file holding offsets, cooldown and thresholds
// ----------------------------------------------------------------------------
module gfg_apb_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gfg_pkg::AddrWidth-1:0]  paddr,
    input  logic [gfg_pkg::DataWidth-1:0]  pwdata,
    output logic [gfg_pkg::DataWidth-1:0]  prdata,
    output gfg_pkg::cfg_t                  cfg
);
    import gfg_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign reg_idx = reg_idx_t'(paddr[AddrWidth-1:2]);
    assign wr_en   = psel & penable & pwrite;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_OFFSET_X:         cfg_next.offset_x         = pwdata[15:0];
                REG_OFFSET_Y:         cfg_next.offset_y         = pwdata[15:0];
                REG_OFFSET_Z:         cfg_next.offset_z         = pwdata[15:0];
                REG_COOLDOWN_MS:      cfg_next.cooldown_ms      = pwdata[15:0];
                REG_ROTATE_THRESHOLD: cfg_next.rotate_threshold = pwdata[22:0];
                REG_DEAD_ZONE:        cfg_next.dead_zone        = pwdata[22:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_x         <= '0;
            cfg_reg.offset_y         <= '0;
            cfg_reg.offset_z         <= '0;
            cfg_reg.cooldown_ms      <= CooldownReset;
            cfg_reg.rotate_threshold <= RotateReset;
            cfg_reg.dead_zone        <= DeadZoneReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux, zero-extended
    always_comb
    begin
        unique case (reg_idx)
            REG_OFFSET_X:         prdata = {16'd0, cfg_reg.offset_x};
            REG_OFFSET_Y:         prdata = {16'd0, cfg_reg.offset_y};
            REG_OFFSET_Z:         prdata = {16'd0, cfg_reg.offset_z};
            REG_COOLDOWN_MS:      prdata = {16'd0, cfg_reg.cooldown_ms};
            REG_ROTATE_THRESHOLD: prdata = {9'd0, cfg_reg.rotate_threshold};
            REG_DEAD_ZONE:        prdata = {9'd0, cfg_reg.dead_zone};
            default:              prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/gfg_filter.sv @@
// ----------------------------------------------------------------------------
// gfg_filter
// One gyro axis: offset removal, first-order low-pass, saturation, dead zone
// ----------------------------------------------------------------------------
module gfg_filter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               update,
    input  logic signed [15:0] raw,
    input  logic signed [15:0] offset,
    input  logic        [22:0] dead_zone,
    output logic signed [23:0] rate
);
    import gfg_pkg::*;

    logic signed [23:0] filt_reg;
    logic signed [23:0] filt_next;
    logic signed [15:0] diff;
    logic signed [33:0] old_ext;
    logic signed [33:0] new_ext;
    logic signed [33:0] acc;
    logic signed [25:0] shifted;
    logic signed [23:0] sat;
    logic        [24:0] mag;

    // offset removal wraps to 16 bits
    assign diff = raw - offset;

    // weighted sum, then floor divide by 256
    assign old_ext = {{10{filt_reg[23]}}, filt_reg};
    assign new_ext = {{10{diff[15]}}, diff, 8'd0};
    assign acc     = KeepWeight * old_ext + NewWeight * new_ext;
    assign shifted = acc[33:8];

    // clamp to the 24-bit rate range
    always_comb
    begin
        priority if (shifted > RateMax)
            sat = 24'sh7FFFFF;
        else if (shifted < RateMin)
            sat = 24'sh800000;
        else
            sat = shifted[23:0];
    end

    // dead zone on the magnitude
    assign mag       = sat[23] ? 25'(-{sat[23], sat}) : {1'b0, sat};
    assign filt_next = (mag < {2'b00, dead_zone}) ? '0 : sat;
    assign rate      = filt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg <= '0;
        end
        else if (update)
        begin
            filt_reg <= filt_next;
        end
    end

endmodule

@@ hdl/gfg_gesture.sv @@
// ----------------------------------------------------------------------------
// gfg_gesture
// Flex and wrist-turn classifier with cooldown and repeat suppression
// ----------------------------------------------------------------------------
module gfg_gesture (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               update,
    input  logic        [11:0] thumb_level,
    input  logic        [11:0] index_level,
    input  logic        [11:0] pinky_level,
    input  logic        [31:0] now_ms,
    input  logic signed [23:0] rate_z,
    input  logic        [15:0] cooldown_ms,
    input  logic        [22:0] rotate_threshold,
    output logic               play,
    output logic        [2:0]  track
);
    import gfg_pkg::*;

    gesture_t           active_reg;
    gesture_t           active_next;
    logic        [31:0] trigger_time_reg;
    logic        [31:0] trigger_time_next;
    logic        [31:0] elapsed;
    logic               armed;
    logic signed [24:0] z_ext;
    logic signed [24:0] rot_pos;
    logic signed [24:0] rot_neg;
    gesture_t           gest;

    function automatic logic z_sign(input logic signed [23:0] v);
        return v[23];
    endfunction

    assign elapsed = now_ms - trigger_time_reg;
    assign armed   = elapsed > {16'd0, cooldown_ms};
    assign z_ext   = {z_sign(rate_z), rate_z};
    assign rot_pos = {2'b00, rotate_threshold};
    assign rot_neg = -rot_pos;

    // fixed-priority gesture pick
    always_comb
    begin
        priority if (index_level >= IndexLo && index_level <= IndexHi)
            gest = GEST_INDEX;
        else if (thumb_level >= ThumbLo && thumb_level <= ThumbHi)
            gest = GEST_THUMB;
        else if (z_ext > rot_pos)
            gest = GEST_TURN_POS;
        else if (z_ext < rot_neg)
            gest = GEST_TURN_NEG;
        else if (pinky_level >= PinkyLo && pinky_level <= PinkyHi)
            gest = GEST_PINKY;
        else
            gest = GEST_NONE;
    end

    // trigger and state update
    always_comb
    begin
        active_next       = active_reg;
        trigger_time_next = trigger_time_reg;
        play              = 1'b0;
        track             = GEST_NONE;
        if (armed)
        begin
            if (gest != GEST_NONE && gest != active_reg)
            begin
                active_next       = gest;
                trigger_time_next = now_ms;
                play              = 1'b1;
                track             = gest;
            end
            else if (gest == GEST_NONE)
            begin
                active_next = GEST_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= GEST_NONE;
            trigger_time_reg <= '0;
        end
        else if (update)
        begin
            active_reg       <= active_next;
            trigger_time_reg <= trigger_time_next;
        end
    end

endmodule

@@ hdl/gyro_flex_gesture_classifier.sv @@
// ----------------------------------------------------------------------------
// gyro_flex_gesture_classifier
// Gyro low-pass with dead zone and flex/turn gesture trigger, one result
// per sample
// ----------------------------------------------------------------------------
//  channel  | role        | transfer
//  ---------+-------------+------------------------------------------------
//  sample   | sink        | gyro x/y/z, thumb/index/pinky levels, now_ms
//  result   | source      | rate x/y/z, play, track
//  apb      | completer   | offsets, cooldown, rotate threshold, dead zone
//
//  a sample lands in the input register, is processed from there and is
//  loaded into the result register
//  one sample per cycle sustained unless the result stalls; filter and
//  gesture state update in the same cycle that the result register loads
//  a stalled result holds the result register; the input register takes
//  the next sample whenever its content moves on in that cycle
//  rst_n clears both valid flags, filter state, gesture state and APB registers
// ----------------------------------------------------------------------------
module gyro_flex_gesture_classifier (
    input  logic                           clk,
    input  logic                           rst_n,
    gfg_in_if.sink                         sample,
    gfg_out_if.source                      result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gfg_pkg::AddrWidth-1:0]  paddr,
    input  logic [gfg_pkg::DataWidth-1:0]  pwdata,
    output logic [gfg_pkg::DataWidth-1:0]  prdata,
    output logic                           pready
);
    import gfg_pkg::*;

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    logic      in_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      advance;
    logic      take;

    assign pready = 1'b1;

    gfg_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // handshake: item moves on when the result register is empty or being taken
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    // per-axis filters
    gfg_filter u_filt_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .update    (advance),
        .raw       (in_item_reg.gyro_raw_x),
        .offset    (cfg.offset_x),
        .dead_zone (cfg.dead_zone),
        .rate      (out_item_next.rate_x)
    );

    gfg_filter u_filt_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .update    (advance),
        .raw       (in_item_reg.gyro_raw_y),
        .offset    (cfg.offset_y),
        .dead_zone (cfg.dead_zone),
        .rate      (out_item_next.rate_y)
    );

    gfg_filter u_filt_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .update    (advance),
        .raw       (in_item_reg.gyro_raw_z),
        .offset    (cfg.offset_z),
        .dead_zone (cfg.dead_zone),
        .rate      (out_item_next.rate_z)
    );

    gfg_gesture u_gesture (
        .clk              (clk),
        .rst_n            (rst_n),
        .update           (advance),
        .thumb_level      (in_item_reg.thumb_level),
        .index_level      (in_item_reg.index_level),
        .pinky_level      (in_item_reg.pinky_level),
        .now_ms           (in_item_reg.now_ms),
        .rate_z           (out_item_next.rate_z),
        .cooldown_ms      (cfg.cooldown_ms),
        .rotate_threshold (cfg.rotate_threshold),
        .play             (out_item_next.play),
        .track            (out_item_next.track)
    );

    // valid flags
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
            in_item_reg <= sample.data;
        if (advance)
            out_item_reg <= out_item_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_item_reg;

endmodule

@@ hdl/gfg_checker.sv @@
// ----------------------------------------------------------------------------
// gfg_checker
// Port-level checks of the gesture classifier, bound to the top level
// ----------------------------------------------------------------------------
`include "gyro_flex_gesture_classifier_defines.svh"

module gfg_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    input  logic       sample_ready,
    input  logic       result_valid,
    input  logic       result_ready,
    input  logic       result_play,
    input  logic [2:0] result_track
);
    import gfg_pkg::*;

    // a waiting result stays offered
    `GFG_CHECK_NEXT(a_result_held, result_valid && !result_ready, result_valid, "result dropped while stalled")

    // track names a gesture exactly when play is set
    `GFG_CHECK(a_play_track, result_valid && result_play, (result_track != GEST_NONE && result_track <= GEST_TURN_NEG), "play without a valid track")
    `GFG_CHECK(a_quiet_track, result_valid && !result_play, (result_track == GEST_NONE), "track set without play")

    // no input back-pressure while the result side is empty
    `GFG_CHECK(a_no_bubble, !result_valid, sample_ready, "input stalled with empty result")

    // a sample taken into an empty pipe shows up at the result
    `GFG_CHECK(a_latency, sample_valid && sample_ready && !result_valid, ##2 result_valid, "result missing after sample transfer")

endmodule

bind gyro_flex_gesture_classifier gfg_checker u_gfg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_play  (result.data.play),
    .result_track (result.data.track)
);

@@ sim/tb_gyro_flex_gesture_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gyro_flex_gesture_classifier
// Self-checking bench for the gyro and flex gesture classifier. A queue of
// sensor samples feeds a valid/ready driver, and a clocked monitor predicts
// each result when its sample transfers and compares every field of the
// returned results in order. Register settings go in over APB between
// phases, once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_gyro_flex_gesture_classifier;
    import gfg_pkg::*;

    // bench timing and limits
    localparam int LongHold    = 200;
    localparam int StuckLimit  = 4000;
    localparam int DrainCycles = 4;
    localparam int RegCount    = 6;

    // register values after reset
    localparam logic [15:0] ResetCooldown = 16'd1000;
    localparam logic [22:0] ResetRotate   = 23'd670720;
    localparam logic [22:0] ResetDeadZone = 23'd16768;

    // flex windows, inclusive
    localparam logic [11:0] WinIndexLo = 12'd1390;
    localparam logic [11:0] WinIndexHi = 12'd1430;
    localparam logic [11:0] WinThumbLo = 12'd1400;
    localparam logic [11:0] WinThumbHi = 12'd1450;
    localparam logic [11:0] WinPinkyLo = 12'd1720;
    localparam logic [11:0] WinPinkyHi = 12'd1780;

    // low-pass weights and 24-bit rate bounds
    localparam longint FiltKeep = 205;
    localparam longint FiltNew  = 51;
    localparam longint RateHi   = 8388607;
    localparam longint RateLo   = -8388608;

    logic clk = 1'b0;
    logic rst_n;

    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [AddrWidth-1:0] paddr;
    logic [DataWidth-1:0] pwdata;
    logic [DataWidth-1:0] prdata;
    logic                 pready;

    gfg_in_if  sample_ch ();
    gfg_out_if result_ch ();

    gyro_flex_gesture_classifier i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    // predictor state and register copy
    cfg_t               model_cfg;
    logic signed [23:0] lp_x;
    logic signed [23:0] lp_y;
    logic signed [23:0] lp_z;
    gesture_t           held_gesture;
    logic        [31:0] last_trigger_ms;

    in_item_t  pending_samples [$];
    out_item_t expected_results [$];

    // stimulus generator state
    logic        [31:0] clock_ms;
    logic signed [15:0] held_raw [3];

    // handshake bookkeeping
    logic sample_taken = 1'b0;
    logic result_taken = 1'b0;
    logic quiet        = 1'b0;
    logic hold_request = 1'b0;
    int   hold_left    = 0;
    int   send_gap     = 0;
    int   take_gap     = 0;
    int   stuck_cycles = 0;
    int   mismatch_count = 0;

    task automatic reset_model();
        model_cfg.offset_x         = '0;
        model_cfg.offset_y         = '0;
        model_cfg.offset_z         = '0;
        model_cfg.cooldown_ms      = ResetCooldown;
        model_cfg.rotate_threshold = ResetRotate;
        model_cfg.dead_zone        = ResetDeadZone;
        lp_x            = '0;
        lp_y            = '0;
        lp_z            = '0;
        held_gesture    = GEST_NONE;
        last_trigger_ms = '0;
    endtask

    // one axis: offset removal with 16-bit wrap, low-pass, saturation, dead zone
    function automatic logic signed [23:0] lowpass_axis(logic signed [23:0] prev,
                                                        logic signed [15:0] raw,
                                                        logic signed [15:0] off);
        logic signed [15:0] centered;
        longint             acc;
        longint             nv;
        longint             mag;
        centered = raw - off;
        acc = FiltKeep * longint'(prev) + FiltNew * (longint'(centered) * 256);
        nv  = acc >>> 8;
        if (nv > RateHi)
            nv = RateHi;
        if (nv < RateLo)
            nv = RateLo;
        mag = (nv < 0) ? -nv : nv;
        if (mag < longint'(model_cfg.dead_zone))
            nv = 0;
        return nv[23:0];
    endfunction

    function automatic bit in_window(logic [11:0] v, logic [11:0] lo, logic [11:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // advance the filters and gesture state for one sample, return its result
    function automatic out_item_t predict_result(in_item_t s);
        out_item_t   r;
        gesture_t    g;
        logic [31:0] since;
        longint      z;
        longint      rot;
        lp_x = lowpass_axis(lp_x, s.gyro_raw_x, model_cfg.offset_x);
        lp_y = lowpass_axis(lp_y, s.gyro_raw_y, model_cfg.offset_y);
        lp_z = lowpass_axis(lp_z, s.gyro_raw_z, model_cfg.offset_z);
        r.rate_x = lp_x;
        r.rate_y = lp_y;
        r.rate_z = lp_z;
        r.play   = 1'b0;
        r.track  = GEST_NONE;
        since = s.now_ms - last_trigger_ms;
        if (since > {16'd0, model_cfg.cooldown_ms})
        begin
            z   = longint'(lp_z);
            rot = longint'(model_cfg.rotate_threshold);
            if (in_window(s.index_level, WinIndexLo, WinIndexHi))
                g = GEST_INDEX;
            else if (in_window(s.thumb_level, WinThumbLo, WinThumbHi))
                g = GEST_THUMB;
            else if (z > rot)
                g = GEST_TURN_POS;
            else if (z < -rot)
                g = GEST_TURN_NEG;
            else if (in_window(s.pinky_level, WinPinkyLo, WinPinkyHi))
                g = GEST_PINKY;
            else
                g = GEST_NONE;
            // a new, different gesture triggers; no gesture clears the current one
            if (g != GEST_NONE && g != held_gesture)
            begin
                held_gesture    = g;
                last_trigger_ms = s.now_ms;
                r.play          = 1'b1;
                r.track         = g;
            end
            else if (g == GEST_NONE)
                held_gesture = GEST_NONE;
        end
        return r;
    endfunction

    task automatic flag_field(string name, logic signed [31:0] want,
                              logic signed [31:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatch_count++;
    endtask

    // transfers on both channels, result checks and the stall watchdog
    always @(posedge clk)
    begin : watch_channels
        out_item_t want;
        out_item_t got;
        sample_taken = rst_n && sample_ch.valid && sample_ch.ready;
        result_taken = rst_n && result_ch.valid && result_ch.ready;
        if (result_taken)
        begin
            got = result_ch.data;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %p", $time, got);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.rate_x !== want.rate_x)
                    flag_field("rate_x", want.rate_x, got.rate_x);
                if (got.rate_y !== want.rate_y)
                    flag_field("rate_y", want.rate_y, got.rate_y);
                if (got.rate_z !== want.rate_z)
                    flag_field("rate_z", want.rate_z, got.rate_z);
                if (got.play !== want.play)
                    flag_field("play", want.play, got.play);
                if (got.track !== want.track)
                    flag_field("track", want.track, got.track);
            end
        end
        if (sample_taken)
            expected_results.push_back(predict_result(sample_ch.data));
        if (rst_n)
        begin
            if (sample_taken || result_taken)
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= StuckLimit)
            begin
                $display("tb_gyro_flex_gesture_classifier: done, errors");
                $finish;
            end
        end
    end

    // sample driver with random idle bursts
    always @(negedge clk)
    begin : feed_samples
        logic     nxt_valid;
        in_item_t nxt_data;
        nxt_valid = sample_ch.valid;
        nxt_data  = sample_ch.data;
        if (rst_n && (!sample_ch.valid || sample_taken))
        begin
            nxt_valid = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if (pending_samples.size() != 0)
            begin
                if (!quiet && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(0, 6);
                else
                begin
                    nxt_valid = 1'b1;
                    nxt_data  = pending_samples.pop_front();
                end
            end
        end
        sample_ch.valid <= nxt_valid;
        sample_ch.data  <= nxt_data;
    end

    // result receiver: random stall bursts and one long hold on request
    always @(negedge clk)
    begin : drain_results
        logic nxt_ready;
        nxt_ready = 1'b0;
        if (rst_n)
        begin
            if (hold_request)
            begin
                hold_left    = LongHold;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
                hold_left--;
            else if (take_gap > 0)
                take_gap--;
            else if (!quiet && $urandom_range(0, 5) == 0)
                take_gap = $urandom_range(0, 6);
            else
                nxt_ready = 1'b1;
        end
        result_ch.ready <= nxt_ready;
    end

    // apb write: setup then access; the register loads at the access edge
    task automatic apb_write(int idx, logic [31:0] value);
        logic [AddrWidth-1:0] addr;
        addr = AddrWidth'(idx * 4);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_OFFSET_X:         model_cfg.offset_x         = value[15:0];
            REG_OFFSET_Y:         model_cfg.offset_y         = value[15:0];
            REG_OFFSET_Z:         model_cfg.offset_z         = value[15:0];
            REG_COOLDOWN_MS:      model_cfg.cooldown_ms      = value[15:0];
            REG_ROTATE_THRESHOLD: model_cfg.rotate_threshold = value[22:0];
            REG_DEAD_ZONE:        model_cfg.dead_zone        = value[22:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write every register with junk above its width, then two unmapped slots
    task automatic program_config(cfg_t c);
        logic [31:0] junk;
        junk = $urandom();
        apb_write(REG_OFFSET_X, {junk[31:16], c.offset_x});
        apb_write(REG_OFFSET_Y, {junk[15:0], c.offset_y});
        apb_write(REG_OFFSET_Z, {~junk[31:16], c.offset_z});
        apb_write(REG_COOLDOWN_MS, {~junk[15:0], c.cooldown_ms});
        apb_write(REG_ROTATE_THRESHOLD, {junk[8:0], c.rotate_threshold});
        apb_write(REG_DEAD_ZONE, {~junk[8:0], c.dead_zone});
        apb_write(RegCount, $urandom());
        apb_write(RegCount + 1, $urandom());
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || sample_ch.valid
               || expected_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    function automatic in_item_t make_sample(int x, int y, int z, int th, int ix, int pk,
                                             logic [31:0] now);
        in_item_t s;
        s.gyro_raw_x  = 16'(x);
        s.gyro_raw_y  = 16'(y);
        s.gyro_raw_z  = 16'(z);
        s.thumb_level = 12'(th);
        s.index_level = 12'(ix);
        s.pinky_level = 12'(pk);
        s.now_ms      = now;
        return s;
    endfunction

    // level inside the window, on its edges, or anywhere
    function automatic logic [11:0] pick_level(logic [11:0] lo, logic [11:0] hi,
                                               int unsigned pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < pct)
            return 12'($urandom_range(hi, lo));
        if (r < pct + 10)
        begin
            case ($urandom_range(0, 3))
                0:       return lo - 12'd1;
                1:       return lo;
                2:       return hi;
                default: return hi + 12'd1;
            endcase
        end
        return 12'($urandom_range(0, 4095));
    endfunction

    // raw reading: noise, near the offset, or a held rate with jitter
    function automatic logic signed [15:0] pick_raw(int axis, logic signed [15:0] off);
        int unsigned r;
        logic signed [15:0] v;
        r = $urandom_range(0, 9);
        if (r < 2)
            v = 16'($urandom());
        else if (r < 4)
            v = 16'(off + ($urandom_range(0, 64) - 32));
        else
        begin
            if ($urandom_range(0, 11) == 0)
                held_raw[axis] = 16'($urandom());
            v = 16'(held_raw[axis] + ($urandom_range(0, 256) - 128));
        end
        return v;
    endfunction

    function automatic in_item_t random_sample();
        in_item_t s;
        if ($urandom_range(0, 31) == 0)
            clock_ms = $urandom();
        else
            clock_ms = clock_ms + $urandom_range(0, 2 * model_cfg.cooldown_ms + 40);
        s.now_ms      = clock_ms;
        s.gyro_raw_x  = pick_raw(0, model_cfg.offset_x);
        s.gyro_raw_y  = pick_raw(1, model_cfg.offset_y);
        s.gyro_raw_z  = pick_raw(2, model_cfg.offset_z);
        s.index_level = pick_level(WinIndexLo, WinIndexHi, 12);
        s.thumb_level = pick_level(WinThumbLo, WinThumbHi, 18);
        s.pinky_level = pick_level(WinPinkyLo, WinPinkyHi, 30);
        return s;
    endfunction

    function automatic logic signed [15:0] pick_offset();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom());
        return 16'($urandom_range(0, 4000) - 2000);
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.offset_x = pick_offset();
        c.offset_y = pick_offset();
        c.offset_z = pick_offset();
        if ($urandom_range(0, 3) == 0)
            c.cooldown_ms = 16'($urandom());
        else
            c.cooldown_ms = 16'($urandom_range(0, 3000));
        if ($urandom_range(0, 3) == 0)
            c.rotate_threshold = 23'($urandom());
        else
            c.rotate_threshold = 23'($urandom_range(0, 3000000));
        if ($urandom_range(0, 3) == 0)
            c.dead_zone = 23'($urandom());
        else
            c.dead_zone = 23'($urandom_range(0, 150000));
        return c;
    endfunction

    task automatic run_random_phase(int n);
        repeat (n) pending_samples.push_back(random_sample());
        wait_drained();
    endtask

    initial
    begin
        cfg_t setting;

        // every input known from time zero
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;
        result_ch.ready = 1'b0;
        clock_ms        = '0;
        for (int a = 0; a < 3; a++)
            held_raw[a] = 16'($urandom());
        reset_model();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset settings: cooldown edge, each track, repeats, clears
        pending_samples.push_back(make_sample(0, 0, 0, 0, 0, 0, 32'd0));
        pending_samples.push_back(make_sample(32767, -32768, 32767, 4095, 4095, 4095, 32'd1000));
        pending_samples.push_back(make_sample(32767, -32768, 32767, 4095, 4095, 4095, 32'd1001));
        pending_samples.push_back(make_sample(32767, -32768, 32767, 4095, 4095, 4095, 32'd2002));
        pending_samples.push_back(make_sample(-32768, 32767, 0, 0, 1390, 0, 32'd3003));
        pending_samples.push_back(make_sample(0, 0, 0, 1400, 1430, 0, 32'd4004));
        pending_samples.push_back(make_sample(0, 0, 0, 1450, 1389, 0, 32'd5005));
        pending_samples.push_back(make_sample(0, 0, -32768, 0, 0, 0, 32'd6006));
        pending_samples.push_back(make_sample(0, 0, -32768, 0, 0, 0, 32'd6007));
        pending_samples.push_back(make_sample(0, 0, 0, 0, 0, 1780, 32'd6010));
        pending_samples.push_back(make_sample(0, 0, 0, 0, 0, 1780, 32'd8000));
        pending_samples.push_back(make_sample(0, 0, 0, 0, 0, 1720, 32'd9100));
        pending_samples.push_back(make_sample(0, 0, 0, 0, 0, 1720, 32'd10200));
        pending_samples.push_back(make_sample(0, 0, 0, 0, 0, 1780, 32'd11300));
        pending_samples.push_back(make_sample(0, 0, 0, 1399, 1431, 1781, 32'd12400));
        pending_samples.push_back(make_sample(0, 0, 0, 1451, 1389, 1719, 32'd13500));
        // wrap of the millisecond counter across the cooldown
        pending_samples.push_back(make_sample(0, 0, 0, 0, 1400, 0, 32'hFFFF_FF00));
        pending_samples.push_back(make_sample(0, 0, 0, 1420, 0, 0, 32'h0000_0100));
        pending_samples.push_back(make_sample(0, 0, 0, 1420, 0, 0, 32'h0000_02E8));
        pending_samples.push_back(make_sample(0, 0, 0, 1420, 0, 0, 32'h0000_02E9));
        wait_drained();

        // low extremes with offsets that make the subtraction wrap
        setting.offset_x         = 16'sh8000;
        setting.offset_y         = 16'sh7FFF;
        setting.offset_z         = 16'sh8000;
        setting.cooldown_ms      = '0;
        setting.rotate_threshold = '0;
        setting.dead_zone        = '0;
        program_config(setting);
        pending_samples.push_back(make_sample(32767, -32768, 32767, 0, 0, 0, 32'd100));
        pending_samples.push_back(make_sample(-32768, 32767, -32768, 0, 0, 1750, 32'd100));
        pending_samples.push_back(make_sample(-32768, 32767, -32768, 0, 0, 1750, 32'd101));
        pending_samples.push_back(make_sample(-32768, 32767, 32767, 0, 0, 0, 32'd101));
        wait_drained();
        run_random_phase(220);

        // high extremes, time starting just below the wrap
        setting.offset_x         = 16'sh7FFF;
        setting.offset_y         = 16'sh8000;
        setting.offset_z         = 16'sh7FFF;
        setting.cooldown_ms      = 16'hFFFF;
        setting.rotate_threshold = 23'h7FFFFF;
        setting.dead_zone        = 23'h7FFFFF;
        program_config(setting);
        clock_ms = 32'hFFF0_0000;
        run_random_phase(160);

        // random settings
        program_config(random_config());
        run_random_phase(220);
        program_config(random_config());
        run_random_phase(220);

        // receiver holds off long while samples keep coming
        program_config(random_config());
        hold_request = 1'b1;
        run_random_phase(220);

        program_config(random_config());
        run_random_phase(220);

        // closing stretch with no idling on either side
        program_config(random_config());
        quiet = 1'b1;
        run_random_phase(220);

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_gyro_flex_gesture_classifier: done, clean");
        else
            $display("tb_gyro_flex_gesture_classifier: done, errors");
        $finish;
    end

endmodule
